// File: sv/ppc_pkg.sv
// Package for the polygon point clamp: widths, codes, beat payload types and
// small arithmetic helpers. No dependencies.
`default_nettype none

package ppc_pkg;

   localparam int MAX_VERT = 64;
   localparam int COORD_W  = 20;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int FOOT_W   = DIFF_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int HALF_W   = PROD_W / 2;
   localparam int NUM_W    = 64;
   localparam int QUO_W    = DIFF_W;
   localparam int STEP_W   = $clog2(QUO_W + 1);
   localparam int CNT_W    = 7;
   localparam int ADDR_W   = $clog2(MAX_VERT);
   localparam int VTX_W    = 2 * COORD_W;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CLAMP  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [1:0] CC_INSIDE = 2'd0;
   localparam logic [1:0] CC_PREV   = 2'd1;
   localparam logic [1:0] CC_NEXT   = 2'd2;
   localparam logic [1:0] CC_VERTEX = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE, S_INS_RD, S_INS_WR, S_REM_RD, S_REM_WR,
      S_CT_RD, S_CT_LD, S_CT_E1, S_CT_E2, S_CT_E3,
      S_NR_RD, S_NR_LD, S_NR_SQ, S_NR_CMP,
      S_PJ_RDA, S_PJ_LDA, S_PJ_RDB, S_PJ_LDB,
      S_PJ_M1, S_PJ_M2, S_PJ_M3, S_PJ_M4, S_PJ_CHK,
      S_PJ_NL, S_PJ_NH, S_PJ_GO, S_PJ_DIV, S_DONE
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vtx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
   } edge_type;

   typedef struct packed {
      logic [1:0]                operation;
      logic [CNT_W-1:0]          vertex_index;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] clamped_x;
      logic signed [COORD_W-1:0] clamped_y;
      logic [1:0]                clamp_case;
      logic [1:0]                status;
      logic [CNT_W-1:0]          vertex_count_now;
   } rsp_type;

   function automatic logic signed [DIFF_W-1:0] sdiff(logic signed [COORD_W-1:0] a,
                                                      logic signed [COORD_W-1:0] b);
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   function automatic logic signed [PROD_W-1:0] smul(logic signed [DIFF_W-1:0] a,
                                                     logic signed [DIFF_W-1:0] b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   // edge with its lower-y end first
   function automatic edge_type order_edge(vtx_type a, vtx_type b);
      edge_type e;
      if (b.y < a.y) begin
         e = {b.x, b.y, a.x, a.y};
      end else begin
         e = {a.x, a.y, b.x, b.y};
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// File: sv/ppc_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on ppc_pkg.
`default_nettype none

interface ppc_req_if;
   logic             valid;
   logic             ready;
   ppc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppc_rsp_if;
   logic             valid;
   logic             ready;
   ppc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/ppc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module ppc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: sv/ppc_div.sv
// Restoring divider, one quotient bit per cycle, rounds half up at the end.
// Depends on ppc_pkg.
`default_nettype none

module ppc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ppc_pkg::NUM_W-1:0]    num,
   input  wire logic [ppc_pkg::PROD_W-1:0]   den,
   output logic                              done,
   output logic      [ppc_pkg::QUO_W-1:0]    quo
);

   logic [ppc_pkg::NUM_W-1:0]  rem_ff, rem_in, dsh_ff, dsh_in;
   logic [ppc_pkg::PROD_W-1:0] den_ff, den_in;
   logic [ppc_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [ppc_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       run_ff, run_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         dsh_in  = ppc_pkg::NUM_W'(den) << (ppc_pkg::QUO_W - 1);
         quo_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (step_ff == ppc_pkg::STEP_W'(ppc_pkg::QUO_W)) begin
            // round: remainder at least half the divisor
            if ((rem_ff << 1) >= ppc_pkg::NUM_W'(den_ff)) begin
               quo_in = quo_ff + ppc_pkg::QUO_W'(1);
            end
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[ppc_pkg::QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[ppc_pkg::QUO_W-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + ppc_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// File: sv/polygon_point_clamp.sv
// Polygon point clamp top level: vertex table in RAM, sequencer, projection.
// Depends on ppc_pkg, ppc_if, ppc_ram, ppc_div.
//
//   channel  | dir | beat contents
//   req_if   | in  | operation, vertex_index, point_x, point_y
//   rsp_if   | out | clamped_x, clamped_y, clamp_case, status, vertex_count_now
//
// Insert shifts vertices up from the end down to the index, remove shifts them down
// from the index to the end, and clamp walks the table before the projections; one
// RAM read port paces every walk and each foot coordinate waits on the divider.
// One beat is worked at a time; a new request is taken while a finished
// response still waits in the output register. Reset clears the vertex count.
`default_nettype none

module polygon_point_clamp (
   input wire logic   clock,
   input wire logic   reset,
   ppc_req_if.sink    req_if,
   ppc_rsp_if.source  rsp_if
);

   ppc_pkg::state_type state_ff, state_in;

   logic [ppc_pkg::CNT_W-1:0]  count_ff, count_in, i_ff, i_in, tgt_ff, tgt_in;
   ppc_pkg::vtx_type           pt_ff, pt_in, first_ff, first_in, prev_ff, prev_in;
   ppc_pkg::vtx_type           cur_ff, cur_in, va_ff, va_in;
   ppc_pkg::edge_type          edge_ff, edge_in;
   logic signed [ppc_pkg::PROD_W-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic signed [ppc_pkg::PROD_W-1:0] sq_ff, sq_in, len2_ff, len2_in, dot_ff, dot_in;
   logic [ppc_pkg::PROD_W-1:0] dist_ff, dist_in, best_ff, best_in;
   logic [ppc_pkg::ADDR_W-1:0] best_i_ff, best_i_in;
   logic signed [ppc_pkg::DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [ppc_pkg::NUM_W-1:0]  num_ff, num_in;
   logic signed [ppc_pkg::COORD_W-1:0] fx_ff, fx_in;
   logic                       par_ff, par_in, last_ff, last_in;
   logic                       side_ff, side_in, axis_ff, axis_in;
   ppc_pkg::rsp_type           res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       mem_we;
   logic [ppc_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
   ppc_pkg::vtx_type           mem_wdata, rd_v;
   logic [ppc_pkg::VTX_W-1:0]  mem_rdata;

   logic                       accept, rsp_load, div_start, div_done;
   logic [ppc_pkg::QUO_W-1:0]  div_quo;
   logic                       ct_last_vtx, ct_skip, cross_hit, pj_fail;
   logic [ppc_pkg::CNT_W-1:0]  prev_idx, next_idx;
   logic signed [ppc_pkg::DIFF_W-1:0] d_sel;
   logic [ppc_pkg::DIFF_W-1:0] d_mag;
   logic [ppc_pkg::PROD_W-1:0] pp;
   logic signed [ppc_pkg::FOOT_W-1:0] q_s, foot;
   logic signed [ppc_pkg::COORD_W-1:0] a_sel;

   ppc_ram #(.WIDTH(ppc_pkg::VTX_W), .DEPTH(ppc_pkg::MAX_VERT)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ppc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (len2_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rd_v          = mem_rdata;
   assign req_if.ready  = (state_ff == ppc_pkg::S_IDLE);
   assign accept        = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_data_ff;
   assign rsp_load      = (state_ff == ppc_pkg::S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   assign ct_last_vtx = (i_ff == count_ff - ppc_pkg::CNT_W'(1));
   assign ct_skip     = (edge_ff.y1 == edge_ff.y2) || (pt_ff.y < edge_ff.y1) ||
                        (pt_ff.y >= edge_ff.y2);
   assign cross_hit   = !(prod_b_ff < prod_a_ff);
   assign pj_fail     = (len2_ff == '0) || dot_ff[ppc_pkg::PROD_W-1] || (dot_ff > len2_ff);
   assign prev_idx    = (best_i_ff == '0) ? count_ff - ppc_pkg::CNT_W'(1)
                                          : ppc_pkg::CNT_W'(best_i_ff) - ppc_pkg::CNT_W'(1);
   assign next_idx    = (ppc_pkg::CNT_W'(best_i_ff) + ppc_pkg::CNT_W'(1) == count_ff) ? '0
                        : ppc_pkg::CNT_W'(best_i_ff) + ppc_pkg::CNT_W'(1);
   assign d_sel       = axis_ff ? dy_ff : dx_ff;
   assign d_mag       = d_sel[ppc_pkg::DIFF_W-1] ? ppc_pkg::DIFF_W'(-d_sel)
                                                 : ppc_pkg::DIFF_W'(d_sel);
   assign pp          = (state_ff == ppc_pkg::S_PJ_NL) ? dot_ff[ppc_pkg::HALF_W-1:0] * d_mag
                        : dot_ff[ppc_pkg::PROD_W-1:ppc_pkg::HALF_W] * d_mag;
   assign q_s         = $signed({1'b0, div_quo});
   assign a_sel       = axis_ff ? va_ff.y : va_ff.x;
   assign foot        = ppc_pkg::FOOT_W'(a_sel) + (d_sel[ppc_pkg::DIFF_W-1] ? -q_s : q_s);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppc_pkg::S_IDLE: begin
            if (accept) begin
               case (req_if.data.operation)
                  ppc_pkg::OP_INSERT: begin
                     if (req_if.data.vertex_index > count_ff ||
                         count_ff == ppc_pkg::CNT_W'(ppc_pkg::MAX_VERT)) begin
                        state_in = ppc_pkg::S_DONE;
                     end else begin
                        state_in = ppc_pkg::S_INS_RD;
                     end
                  end
                  ppc_pkg::OP_REMOVE: begin
                     state_in = (req_if.data.vertex_index >= count_ff) ? ppc_pkg::S_DONE
                                                                       : ppc_pkg::S_REM_RD;
                  end
                  ppc_pkg::OP_CLAMP: begin
                     state_in = (count_ff == '0) ? ppc_pkg::S_DONE : ppc_pkg::S_CT_RD;
                  end
                  default: state_in = ppc_pkg::S_DONE;
               endcase
            end
         end
         ppc_pkg::S_INS_RD: state_in = ppc_pkg::S_INS_WR;
         ppc_pkg::S_INS_WR: state_in = (i_ff == tgt_ff) ? ppc_pkg::S_DONE : ppc_pkg::S_INS_RD;
         ppc_pkg::S_REM_RD: state_in = ct_last_vtx ? ppc_pkg::S_DONE : ppc_pkg::S_REM_WR;
         ppc_pkg::S_REM_WR: state_in = ppc_pkg::S_REM_RD;
         ppc_pkg::S_CT_RD:  state_in = ppc_pkg::S_CT_LD;
         ppc_pkg::S_CT_LD: begin
            if (i_ff != '0) begin
               state_in = ppc_pkg::S_CT_E1;
            end else if (count_ff == ppc_pkg::CNT_W'(1)) begin
               state_in = ppc_pkg::S_NR_RD;
            end else begin
               state_in = ppc_pkg::S_CT_RD;
            end
         end
         ppc_pkg::S_CT_E1, ppc_pkg::S_CT_E3: begin
            if (state_ff == ppc_pkg::S_CT_E1 && !ct_skip) begin
               state_in = ppc_pkg::S_CT_E2;
            end else if (last_ff) begin
               if (par_ff ^ (state_ff == ppc_pkg::S_CT_E3 && cross_hit)) begin
                  state_in = ppc_pkg::S_DONE;
               end else begin
                  state_in = ppc_pkg::S_NR_RD;
               end
            end else if (ct_last_vtx) begin
               state_in = ppc_pkg::S_CT_E1;
            end else begin
               state_in = ppc_pkg::S_CT_RD;
            end
         end
         ppc_pkg::S_CT_E2:  state_in = ppc_pkg::S_CT_E3;
         ppc_pkg::S_NR_RD:  state_in = ppc_pkg::S_NR_LD;
         ppc_pkg::S_NR_LD:  state_in = ppc_pkg::S_NR_SQ;
         ppc_pkg::S_NR_SQ:  state_in = ppc_pkg::S_NR_CMP;
         ppc_pkg::S_NR_CMP: state_in = ct_last_vtx ? ppc_pkg::S_PJ_RDA : ppc_pkg::S_NR_RD;
         ppc_pkg::S_PJ_RDA: state_in = ppc_pkg::S_PJ_LDA;
         ppc_pkg::S_PJ_LDA: state_in = ppc_pkg::S_PJ_RDB;
         ppc_pkg::S_PJ_RDB: state_in = ppc_pkg::S_PJ_LDB;
         ppc_pkg::S_PJ_LDB: state_in = ppc_pkg::S_PJ_M1;
         ppc_pkg::S_PJ_M1:  state_in = ppc_pkg::S_PJ_M2;
         ppc_pkg::S_PJ_M2:  state_in = ppc_pkg::S_PJ_M3;
         ppc_pkg::S_PJ_M3:  state_in = ppc_pkg::S_PJ_M4;
         ppc_pkg::S_PJ_M4:  state_in = ppc_pkg::S_PJ_CHK;
         ppc_pkg::S_PJ_CHK: begin
            if (!pj_fail) begin
               state_in = ppc_pkg::S_PJ_NL;
            end else begin
               state_in = side_ff ? ppc_pkg::S_DONE : ppc_pkg::S_PJ_RDB;
            end
         end
         ppc_pkg::S_PJ_NL:  state_in = ppc_pkg::S_PJ_NH;
         ppc_pkg::S_PJ_NH:  state_in = ppc_pkg::S_PJ_GO;
         ppc_pkg::S_PJ_GO:  state_in = ppc_pkg::S_PJ_DIV;
         ppc_pkg::S_PJ_DIV: begin
            if (div_done) begin
               state_in = axis_ff ? ppc_pkg::S_DONE : ppc_pkg::S_PJ_NL;
            end
         end
         ppc_pkg::S_DONE:   state_in = rsp_load ? ppc_pkg::S_IDLE : ppc_pkg::S_DONE;
         default:           state_in = ppc_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in  = count_ff;
      i_in      = i_ff;
      tgt_in    = tgt_ff;
      pt_in     = pt_ff;
      first_in  = first_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      va_in     = va_ff;
      edge_in   = edge_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      sq_in     = sq_ff;
      len2_in   = len2_ff;
      dot_in    = dot_ff;
      dist_in   = dist_ff;
      best_in   = best_ff;
      best_i_in = best_i_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      num_in    = num_ff;
      fx_in     = fx_ff;
      par_in    = par_ff;
      last_in   = last_ff;
      side_in   = side_ff;
      axis_in   = axis_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = i_ff[ppc_pkg::ADDR_W-1:0];
      mem_wdata = rd_v;
      mem_raddr = i_ff[ppc_pkg::ADDR_W-1:0];
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ppc_pkg::S_IDLE: begin
            if (accept) begin
               pt_in   = {req_if.data.point_x, req_if.data.point_y};
               tgt_in  = req_if.data.vertex_index;
               par_in  = 1'b0;
               last_in = 1'b0;
               side_in = 1'b0;
               res_in  = '0;
               case (req_if.data.operation)
                  ppc_pkg::OP_INSERT: begin
                     i_in = count_ff;
                     if (req_if.data.vertex_index > count_ff) begin
                        res_in.status = ppc_pkg::ST_RANGE;
                     end else if (count_ff == ppc_pkg::CNT_W'(ppc_pkg::MAX_VERT)) begin
                        res_in.status = ppc_pkg::ST_FULL;
                     end
                  end
                  ppc_pkg::OP_REMOVE: begin
                     i_in = req_if.data.vertex_index;
                     if (req_if.data.vertex_index >= count_ff) begin
                        res_in.status = ppc_pkg::ST_RANGE;
                     end
                  end
                  ppc_pkg::OP_CLAMP: begin
                     i_in = '0;
                     res_in.clamped_x = req_if.data.point_x;
                     res_in.clamped_y = req_if.data.point_y;
                  end
                  default: i_in = '0;
               endcase
            end
         end
         ppc_pkg::S_INS_RD: begin
            mem_raddr = ppc_pkg::ADDR_W'(i_ff - ppc_pkg::CNT_W'(1));
         end
         ppc_pkg::S_INS_WR: begin
            mem_we = 1'b1;
            if (i_ff == tgt_ff) begin
               mem_wdata = pt_ff;
               count_in  = count_ff + ppc_pkg::CNT_W'(1);
            end else begin
               i_in = i_ff - ppc_pkg::CNT_W'(1);
            end
         end
         ppc_pkg::S_REM_RD: begin
            mem_raddr = ppc_pkg::ADDR_W'(i_ff + ppc_pkg::CNT_W'(1));
            if (ct_last_vtx) begin
               count_in = count_ff - ppc_pkg::CNT_W'(1);
            end
         end
         ppc_pkg::S_REM_WR: begin
            mem_we = 1'b1;
            i_in   = i_ff + ppc_pkg::CNT_W'(1);
         end
         ppc_pkg::S_CT_LD: begin
            prev_in = rd_v;
            if (i_ff == '0) begin
               first_in = rd_v;
            end else begin
               edge_in = ppc_pkg::order_edge(prev_ff, rd_v);
            end
            if (i_ff == '0 && count_ff != ppc_pkg::CNT_W'(1)) begin
               i_in = ppc_pkg::CNT_W'(1);
            end
         end
         ppc_pkg::S_CT_E1, ppc_pkg::S_CT_E3: begin
            if (state_ff == ppc_pkg::S_CT_E1 && !ct_skip) begin
               prod_a_in = ppc_pkg::smul(ppc_pkg::sdiff(edge_ff.x2, edge_ff.x1),
                                         ppc_pkg::sdiff(pt_ff.y, edge_ff.y1));
            end else begin
               if (state_ff == ppc_pkg::S_CT_E3 && cross_hit) begin
                  par_in = !par_ff;
               end
               if (last_ff) begin
                  i_in = '0;
               end else if (ct_last_vtx) begin
                  // closing edge back to vertex zero
                  edge_in = ppc_pkg::order_edge(prev_ff, first_ff);
                  last_in = 1'b1;
               end else begin
                  i_in = i_ff + ppc_pkg::CNT_W'(1);
               end
            end
         end
         ppc_pkg::S_CT_E2: begin
            prod_b_in = ppc_pkg::smul(ppc_pkg::sdiff(pt_ff.x, edge_ff.x1),
                                      ppc_pkg::sdiff(edge_ff.y2, edge_ff.y1));
         end
         ppc_pkg::S_NR_LD: begin
            cur_in = rd_v;
            sq_in  = ppc_pkg::smul(ppc_pkg::sdiff(rd_v.x, pt_ff.x),
                                   ppc_pkg::sdiff(rd_v.x, pt_ff.x));
         end
         ppc_pkg::S_NR_SQ: begin
            dist_in = ppc_pkg::PROD_W'(sq_ff + ppc_pkg::smul(ppc_pkg::sdiff(cur_ff.y, pt_ff.y),
                                                            ppc_pkg::sdiff(cur_ff.y, pt_ff.y)));
         end
         ppc_pkg::S_NR_CMP: begin
            if (i_ff == '0 || dist_ff < best_ff) begin
               best_in   = dist_ff;
               best_i_in = i_ff[ppc_pkg::ADDR_W-1:0];
            end
            i_in = i_ff + ppc_pkg::CNT_W'(1);
         end
         ppc_pkg::S_PJ_RDA: begin
            mem_raddr = best_i_ff;
         end
         ppc_pkg::S_PJ_LDA: begin
            va_in = rd_v;
         end
         ppc_pkg::S_PJ_RDB: begin
            mem_raddr = side_ff ? next_idx[ppc_pkg::ADDR_W-1:0] : prev_idx[ppc_pkg::ADDR_W-1:0];
         end
         ppc_pkg::S_PJ_LDB: begin
            dx_in = ppc_pkg::sdiff(rd_v.x, va_ff.x);
            dy_in = ppc_pkg::sdiff(rd_v.y, va_ff.y);
         end
         ppc_pkg::S_PJ_M1: sq_in   = ppc_pkg::smul(dx_ff, dx_ff);
         ppc_pkg::S_PJ_M2: len2_in = sq_ff + ppc_pkg::smul(dy_ff, dy_ff);
         ppc_pkg::S_PJ_M3: sq_in   = ppc_pkg::smul(ppc_pkg::sdiff(pt_ff.x, va_ff.x), dx_ff);
         ppc_pkg::S_PJ_M4: dot_in  = sq_ff + ppc_pkg::smul(ppc_pkg::sdiff(pt_ff.y, va_ff.y),
                                                           dy_ff);
         ppc_pkg::S_PJ_CHK: begin
            axis_in = 1'b0;
            if (pj_fail) begin
               if (side_ff) begin
                  res_in.clamped_x  = va_ff.x;
                  res_in.clamped_y  = va_ff.y;
                  res_in.clamp_case = ppc_pkg::CC_VERTEX;
               end else begin
                  side_in = 1'b1;
               end
            end
         end
         ppc_pkg::S_PJ_NL: num_in = ppc_pkg::NUM_W'(pp);
         ppc_pkg::S_PJ_NH: num_in = num_ff + (ppc_pkg::NUM_W'(pp) << ppc_pkg::HALF_W);
         ppc_pkg::S_PJ_GO: div_start = 1'b1;
         ppc_pkg::S_PJ_DIV: begin
            if (div_done) begin
               if (axis_ff) begin
                  res_in.clamped_x  = fx_ff;
                  res_in.clamped_y  = ppc_pkg::COORD_W'(foot);
                  res_in.clamp_case = side_ff ? ppc_pkg::CC_NEXT : ppc_pkg::CC_PREV;
               end else begin
                  fx_in   = ppc_pkg::COORD_W'(foot);
                  axis_in = 1'b1;
               end
            end
         end
         ppc_pkg::S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_data_in.vertex_count_now = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppc_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      tgt_ff      <= tgt_in;
      pt_ff       <= pt_in;
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      va_ff       <= va_in;
      edge_ff     <= edge_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      sq_ff       <= sq_in;
      len2_ff     <= len2_in;
      dot_ff      <= dot_in;
      dist_ff     <= dist_in;
      best_ff     <= best_in;
      best_i_ff   <= best_i_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      num_ff      <= num_in;
      fx_ff       <= fx_in;
      par_ff      <= par_in;
      last_ff     <= last_in;
      side_ff     <= side_in;
      axis_ff     <= axis_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ppc_pkg::CNT_W'(ppc_pkg::MAX_VERT))
      else $error("vertex count above table size");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == ppc_pkg::S_INS_WR || $past(state_ff) == ppc_pkg::S_REM_RD))
      else $error("vertex count moved outside insert or remove");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ppc_pkg::S_PJ_DIV))
      else $error("divider finished while not awaited");

endmodule

`default_nettype wire

// File: test/polygon_point_clamp_tb.sv
// Self-checking testbench for polygon_point_clamp: random and directed vertex
// table edits and clamp queries, checked against an in-bench predictor.
// Depends on ppc_pkg, ppc_if and the polygon_point_clamp RTL.
`default_nettype none

module polygon_point_clamp_tb;

   class clamp_scoreboard;
      longint           vx[ppc_pkg::MAX_VERT];
      longint           vy[ppc_pkg::MAX_VERT];
      int               vcount;
      ppc_pkg::rsp_type expected_q[$];
      int               errors;

      function new();
         vcount = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // even-odd test, ray toward minus x
      function bit in_poly(longint px, longint py);
         longint x1, y1, x2, y2, t;
         int     j;
         int     hits;
         hits = 0;
         for (int i = 0; i < vcount; i++) begin
            j  = (i + 1 == vcount) ? 0 : i + 1;
            x1 = vx[i]; y1 = vy[i]; x2 = vx[j]; y2 = vy[j];
            if (y1 == y2) continue;
            if (y2 < y1) begin
               t = x1; x1 = x2; x2 = t;
               t = y1; y1 = y2; y2 = t;
            end
            if (py >= y1 && py < y2) begin
               if (!((px - x1) * (y2 - y1) < (x2 - x1) * (py - y1))) hits++;
            end
         end
         return hits[0];
      endfunction

      function longint foot_offset(longint dot, longint d, longint len2);
         logic [127:0] num, q, r;
         longint       m;
         m   = (d < 0) ? -d : d;
         num = 128'(dot) * 128'(m);
         q   = num / 128'(len2);
         r   = num % 128'(len2);
         if (2 * r >= 128'(len2)) q++;
         return (d < 0) ? -longint'(q) : longint'(q);
      endfunction

      function bit project_edge(int v, int w, longint px, longint py,
                                output longint fx, output longint fy);
         longint dx, dy, len2, dot;
         fx   = 0;
         fy   = 0;
         dx   = vx[w] - vx[v];
         dy   = vy[w] - vy[v];
         len2 = dx * dx + dy * dy;
         if (len2 == 0) return 0;
         dot = (px - vx[v]) * dx + (py - vy[v]) * dy;
         if (dot < 0 || dot > len2) return 0;
         fx = vx[v] + foot_offset(dot, dx, len2);
         fy = vy[v] + foot_offset(dot, dy, len2);
         return 1;
      endfunction

      function void note_request(ppc_pkg::req_type rq);
         ppc_pkg::rsp_type e;
         longint  px, py, ox, oy, d, bestd, fx, fy;
         int      idx, best, prv, nxt;
         e   = '0;
         px  = longint'(rq.point_x);
         py  = longint'(rq.point_y);
         idx = rq.vertex_index;
         ox  = 0;
         oy  = 0;
         case (rq.operation)
            ppc_pkg::OP_INSERT: begin
               if (idx > vcount) e.status = ppc_pkg::ST_RANGE;
               else if (vcount >= ppc_pkg::MAX_VERT) e.status = ppc_pkg::ST_FULL;
               else begin
                  for (int i = vcount; i > idx; i--) begin
                     vx[i] = vx[i-1];
                     vy[i] = vy[i-1];
                  end
                  vx[idx] = px;
                  vy[idx] = py;
                  vcount++;
               end
            end
            ppc_pkg::OP_REMOVE: begin
               if (idx >= vcount) e.status = ppc_pkg::ST_RANGE;
               else begin
                  for (int i = idx; i + 1 < vcount; i++) begin
                     vx[i] = vx[i+1];
                     vy[i] = vy[i+1];
                  end
                  vcount--;
               end
            end
            ppc_pkg::OP_CLAMP: begin
               ox = px;
               oy = py;
               e.clamp_case = ppc_pkg::CC_INSIDE;
               if (vcount != 0 && !in_poly(px, py)) begin
                  best  = 0;
                  bestd = (vx[0] - px) * (vx[0] - px) + (vy[0] - py) * (vy[0] - py);
                  for (int i = 1; i < vcount; i++) begin
                     d = (vx[i] - px) * (vx[i] - px) + (vy[i] - py) * (vy[i] - py);
                     if (d < bestd) begin
                        bestd = d;
                        best  = i;
                     end
                  end
                  prv = (best == 0) ? vcount - 1 : best - 1;
                  nxt = (best + 1 == vcount) ? 0 : best + 1;
                  if (project_edge(best, prv, px, py, fx, fy)) begin
                     e.clamp_case = ppc_pkg::CC_PREV;
                     ox = fx; oy = fy;
                  end else if (project_edge(best, nxt, px, py, fx, fy)) begin
                     e.clamp_case = ppc_pkg::CC_NEXT;
                     ox = fx; oy = fy;
                  end else begin
                     e.clamp_case = ppc_pkg::CC_VERTEX;
                     ox = vx[best]; oy = vy[best];
                  end
               end
            end
            default: ;
         endcase
         e.clamped_x        = ppc_pkg::COORD_W'(ox);
         e.clamped_y        = ppc_pkg::COORD_W'(oy);
         e.vertex_count_now = ppc_pkg::CNT_W'(vcount);
         expected_q.push_back(e);
      endfunction

      function void check_response(ppc_pkg::rsp_type got);
         ppc_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.clamped_x !== e.clamped_x) begin
            $display("%0t: clamped_x exp %0d got %0d", $time, e.clamped_x, got.clamped_x);
            errors++;
         end
         if (got.clamped_y !== e.clamped_y) begin
            $display("%0t: clamped_y exp %0d got %0d", $time, e.clamped_y, got.clamped_y);
            errors++;
         end
         if (got.clamp_case !== e.clamp_case) begin
            $display("%0t: clamp_case exp %0d got %0d", $time, e.clamp_case, got.clamp_case);
            errors++;
         end
         if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.vertex_count_now !== e.vertex_count_now) begin
            $display("%0t: vertex_count_now exp %0d got %0d", $time,
                     e.vertex_count_now, got.vertex_count_now);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   ppc_req_if req_if();
   ppc_rsp_if rsp_if();

   polygon_point_clamp uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   clamp_scoreboard sb = new();
   bit  tx_quiet;
   bit  hold_rsp;
   int  item_num;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("FAIL");
      $finish;
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int cyc;
      cyc = 0;
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_rsp) begin
            rsp_if.ready = 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         if (cyc > 30000 && cyc < 45000) rsp_if.ready = 1;
         else rsp_if.ready = ($urandom_range(99) >= 32);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
   end

   task automatic send_beat(logic [1:0] op, int idx, longint x, longint y);
      ppc_pkg::req_type rq;
      while (!tx_quiet && $urandom_range(99) < 32) begin
         req_if.valid = 0;
         @(negedge clock);
      end
      rq.operation    = op;
      rq.vertex_index = ppc_pkg::CNT_W'(idx);
      rq.point_x      = ppc_pkg::COORD_W'(x);
      rq.point_y      = ppc_pkg::COORD_W'(y);
      req_if.data  = rq;
      req_if.valid = 1;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(rq);
      item_num++;
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic longint rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 15) return longint'($signed(ppc_pkg::COORD_W'($urandom)));
      if (r < 20) return (r[0]) ? -524288 : 524287;
      return longint'($urandom_range(600000)) - 300000;
   endfunction

   initial begin
      int     r, op, idx;
      longint x, y;
      item_num      = 0;
      tx_quiet      = 0;
      hold_rsp      = 0;
      req_if.valid  = 0;
      req_if.data   = '0;
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty table, range errors, a square, edge cases
      send_beat(ppc_pkg::OP_CLAMP, 0, 1000, -1000);
      send_beat(ppc_pkg::OP_REMOVE, 0, 0, 0);
      send_beat(ppc_pkg::OP_INSERT, 1, 5, 5);
      send_beat(ppc_pkg::OP_INSERT, 0, -131072, -131072);
      send_beat(ppc_pkg::OP_CLAMP, 0, 524287, 524287);
      send_beat(ppc_pkg::OP_INSERT, 1, 131072, -131072);
      send_beat(ppc_pkg::OP_CLAMP, 0, 0, 300000);
      send_beat(ppc_pkg::OP_INSERT, 2, 131072, 131072);
      send_beat(ppc_pkg::OP_INSERT, 3, -131072, 131072);
      send_beat(ppc_pkg::OP_CLAMP, 0, 0, 0);
      send_beat(ppc_pkg::OP_CLAMP, 0, 300000, 10000);
      send_beat(ppc_pkg::OP_CLAMP, 0, -524288, -524288);
      send_beat(ppc_pkg::OP_CLAMP, 0, 524287, -524288);
      send_beat(ppc_pkg::OP_CLAMP, 0, 131072, 131072);
      send_beat(ppc_pkg::OP_CLAMP, 0, -131072, 0);
      send_beat(2'd3, 5, 77, 77);
      send_beat(ppc_pkg::OP_INSERT, 0, 7, 7);
      send_beat(ppc_pkg::OP_REMOVE, 0, 0, 0);
      send_beat(ppc_pkg::OP_INSERT, 4, -131072, 131072);   // zero-length edge
      send_beat(ppc_pkg::OP_CLAMP, 0, -200000, 140000);
      send_beat(ppc_pkg::OP_REMOVE, 5, 0, 0);
      send_beat(ppc_pkg::OP_REMOVE, 4, 0, 0);
      // fill to capacity, then overflow and bad index
      while (sb.vcount < ppc_pkg::MAX_VERT)
         send_beat(ppc_pkg::OP_INSERT, $urandom_range(sb.vcount), rand_coord(), rand_coord());
      send_beat(ppc_pkg::OP_INSERT, ppc_pkg::MAX_VERT, 1, 1);
      send_beat(ppc_pkg::OP_INSERT, 127, 1, 1);
      send_beat(ppc_pkg::OP_CLAMP, 0, rand_coord(), rand_coord());
      while (sb.vcount > 4)
         send_beat(ppc_pkg::OP_REMOVE, $urandom_range(sb.vcount - 1), 0, 0);

      for (int n = 0; n < 300; n++) begin
         tx_quiet = (n >= 150 && n < 230);
         if (n == 60) hold_rsp = 1;
         if (n == 250) begin
            req_if.valid = 0;
            drain();
            @(negedge clock);
         end
         r = $urandom_range(99);
         x = rand_coord();
         y = rand_coord();
         if (r < 5) begin
            op  = $urandom_range(3);
            idx = $urandom_range(127);
         end else if (r < 45) begin
            op  = (sb.vcount < 3 || (sb.vcount < 14 && r < 32)) ? ppc_pkg::OP_INSERT
                                                                 : ppc_pkg::OP_REMOVE;
            idx = (op == ppc_pkg::OP_INSERT) ? $urandom_range(sb.vcount)
                                    : $urandom_range(sb.vcount > 0 ? sb.vcount - 1 : 0);
         end else begin
            op  = ppc_pkg::OP_CLAMP;
            idx = $urandom_range(127);
            if (r < 52 && sb.vcount > 0) begin
               x = sb.vx[$urandom_range(sb.vcount - 1)];
               y = sb.vy[$urandom_range(sb.vcount - 1)];
            end
         end
         send_beat(op[1:0], idx, x, y);
      end
      req_if.valid = 0;

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
